FILE: rtl/emks_pkg.sv
// ----------------------------------------------------------------------------
// emks_pkg
// Shared types and constants for the exact match key set.
// ----------------------------------------------------------------------------
package emks_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int KEY_FIELD_W   = 32;
  localparam int COUNT_FIELD_W = 7;
  localparam int MODE_W        = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // control token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic [MODE_W-1:0] mode;
    logic              hit;
    logic              free_found;
  } cell_ctl_t;

endpackage

FILE: rtl/emks_in_if.sv
// ----------------------------------------------------------------------------
// emks_in_if
// Request channel: operation mode and key.
// ----------------------------------------------------------------------------
interface emks_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

FILE: rtl/emks_out_if.sv
// ----------------------------------------------------------------------------
// emks_out_if
// Result channel: success, full flag and entry count.
// ----------------------------------------------------------------------------
interface emks_out_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic       table_full;
  logic [6:0] entry_count;

  modport source (output valid, output success, output table_full,
                  output entry_count, input ready);
  modport sink (input valid, input success, input table_full,
                input entry_count, output ready);
endinterface

FILE: rtl/exact_match_key_set_unit.sv
// ----------------------------------------------------------------------------
// exact_match_key_set_unit
// Set of up to CAPACITY distinct keys with insert, remove and membership test.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel (valid/ready): mode and key. Mode insert adds a
//            new key in the lowest free entry, remove deletes a held key,
//            test reports whether the key is held. Key bits above KEY_WIDTH
//            are ignored.
//   result - one transaction per request: success, table_full, entry_count
//            (keys held after the operation, low 7 bits).
//   A request walks the row of CAPACITY entry cells, one cell per cycle.
//   The result is registered in the finish state once the request leaves
//   the row, and a new request is taken only back in idle, so the block
//   holds one request at a time; the length of the cell row sets its delay.
//   Reset empties the table at once and clears the count.
//   The result sits in an output register; a stalled receiver holds a
//   finished request at the end of the row until that register is free,
//   and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module exact_match_key_set_unit
  import emks_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  emks_in_if.sink      item,
  emks_out_if.source   result
);

  localparam int KEY_W = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  cell_ctl_t        head_ctl;
  cell_ctl_t        tail_ctl;
  logic [KEY_W-1:0] tail_key;
  logic [IDX_W-1:0] tail_free_idx;

  logic [MODE_W-1:0] fin_mode;
  logic              fin_hit;
  logic              fin_free_found;
  logic [IDX_W-1:0]  fin_free_idx;
  logic [KEY_W-1:0]  fin_key;

  logic accept;
  logic commit;
  logic ok;
  logic full;
  logic wr_en;

  assign accept = item.valid && item.ready;

  always_comb begin
    head_ctl.active     = accept;
    head_ctl.mode       = item.mode;
    head_ctl.hit        = 1'b0;
    head_ctl.free_found = 1'b0;
  end

  emks_chain #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_W),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk           (clk),
    .rst           (rst),
    .head_ctl      (head_ctl),
    .head_key      (item.key[KEY_W-1:0]),
    .tail_ctl      (tail_ctl),
    .tail_key      (tail_key),
    .tail_free_idx (tail_free_idx),
    .wr_en         (wr_en),
    .wr_idx        (fin_free_idx),
    .wr_key        (fin_key)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (tail_ctl.active) state_next = ST_FINISH;
      ST_FINISH: if (!result.valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_IDLE:   item.ready = 1'b1;
      ST_SCAN:   commit = 1'b0;
      ST_FINISH: commit = !result.valid || result.ready;
      default:   commit = 1'b0;
    endcase
  end

  always_comb begin
    ok         = 1'b0;
    full       = 1'b0;
    count_next = count;
    case (fin_mode)
      MODE_INSERT: begin
        ok   = !fin_hit && fin_free_found;
        full = !fin_hit && !fin_free_found;
        if (ok) count_next = count + CNT_W'(1);
      end
      MODE_REMOVE: begin
        ok = fin_hit;
        if (fin_hit && (count != '0)) count_next = count - CNT_W'(1);
      end
      MODE_TEST: ok = fin_hit;
      default:   ok = 1'b0;
    endcase
  end

  assign wr_en = commit && (fin_mode == MODE_INSERT) && ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count        <= count_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tail_ctl.active) begin
      fin_mode       <= tail_ctl.mode;
      fin_hit        <= tail_ctl.hit;
      fin_free_found <= tail_ctl.free_found;
      fin_free_idx   <= tail_free_idx;
      fin_key        <= tail_key;
    end
    if (commit) begin
      result.success     <= ok;
      result.table_full  <= full;
      result.entry_count <= COUNT_FIELD_W'(count_next);
    end
  end

endmodule

FILE: rtl/emks_cell.sv
// ----------------------------------------------------------------------------
// emks_cell
// One table entry: compares the passing key, clears itself on a matching
// remove, claims the free slot if it is the first empty one, and takes a
// broadcast write addressed to it.
// ----------------------------------------------------------------------------
module emks_cell
  import emks_pkg::*;
#(
  parameter int KEY_W = KEY_WIDTH_DEF,
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl_in,
  input  logic [KEY_W-1:0] key_in,
  input  logic [IDX_W-1:0] free_idx_in,
  output cell_ctl_t        ctl_out,
  output logic [KEY_W-1:0] key_out,
  output logic [IDX_W-1:0] free_idx_out,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [KEY_W-1:0] wr_key
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic             match;
  logic             claim;
  cell_ctl_t        ctl_next;

  assign match = valid && (key == key_in);
  assign claim = !ctl_in.free_found && !valid;

  always_comb begin
    ctl_next            = ctl_in;
    ctl_next.hit        = ctl_in.hit | match;
    ctl_next.free_found = ctl_in.free_found | claim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
        valid <= 1'b1;
      end else if (ctl_in.active && (ctl_in.mode == MODE_REMOVE) && match) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctl_out.active     <= rst ? 1'b0 : ctl_next.active;
    ctl_out.mode       <= ctl_next.mode;
    ctl_out.hit        <= ctl_next.hit;
    ctl_out.free_found <= ctl_next.free_found;
    key_out            <= key_in;
    free_idx_out       <= claim ? IDX_W'(INDEX) : free_idx_in;
    if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
      key <= wr_key;
    end
  end

endmodule

FILE: rtl/emks_chain.sv
// ----------------------------------------------------------------------------
// emks_chain
// Row of entry cells; the lookup token moves one cell per cycle.
// ----------------------------------------------------------------------------
module emks_chain
  import emks_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_W    = KEY_WIDTH_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        head_ctl,
  input  logic [KEY_W-1:0] head_key,
  output cell_ctl_t        tail_ctl,
  output logic [KEY_W-1:0] tail_key,
  output logic [IDX_W-1:0] tail_free_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [KEY_W-1:0] wr_key
);

  cell_ctl_t        ctl [CAPACITY+1];
  logic [KEY_W-1:0] keys [CAPACITY+1];
  logic [IDX_W-1:0] fidx [CAPACITY+1];

  assign ctl[0]  = head_ctl;
  assign keys[0] = head_key;
  assign fidx[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    emks_cell #(
      .KEY_W (KEY_W),
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl_in       (ctl[i]),
      .key_in       (keys[i]),
      .free_idx_in  (fidx[i]),
      .ctl_out      (ctl[i+1]),
      .key_out      (keys[i+1]),
      .free_idx_out (fidx[i+1]),
      .wr_en        (wr_en),
      .wr_idx       (wr_idx),
      .wr_key       (wr_key)
    );
  end

  assign tail_ctl      = ctl[CAPACITY];
  assign tail_key      = keys[CAPACITY];
  assign tail_free_idx = fidx[CAPACITY];

endmodule
